// File: rtl/kvt_pkg.sv
// Package for the key/value table: response codes and request opcodes.
// No dependencies; used by all files of the block.
package kvt_pkg;
   localparam logic [1:0] RSP_FOUND  = 2'd0;
   localparam logic [1:0] RSP_MISS   = 2'd1;
   localparam logic [1:0] RSP_STORED = 2'd2;
   localparam logic [1:0] RSP_ERROR  = 2'd3;
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_SET = 1'b1;

   // Per-cell search result handed along the chain.
   typedef struct packed {
      logic hit_found;
      logic free_found;
   } chain_type;

   function automatic logic [63:0] byte_mask(input logic [4:0] len, input logic [4:0] base);
      logic [63:0] m;
      logic [4:0]  n;
      m = '0;
      n = len - base;
      if (len > base) begin
         if (n >= 5'd8) m = '1;
         else m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
      end
      return m;
   endfunction
endpackage

// File: rtl/kvt_cell.sv
// One table entry: stored key, value and flags plus its own compare.
// Depends on kvt_pkg.
module kvt_cell
   import kvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [4:0]   key_len,
   input  logic [127:0] key,
   input  logic         wr_en,
   input  logic [4:0]   wr_vlen,
   input  logic [127:0] wr_value,
   input  logic [31:0]  wr_flags,
   input  logic [31:0]  wr_expiry,
   input  chain_type    chain_in,
   output chain_type    chain_out,
   output logic         hit,
   output logic         first_free,
   output logic [4:0]   stored_vlen,
   output logic [127:0] value,
   output logic [31:0]  flags
);
   logic         valid_ff;
   logic [4:0]   key_len_ff;
   logic [127:0] key_ff;
   logic [4:0]   vlen_ff;
   logic [127:0] value_ff;
   logic [31:0]  flags_ff;
   logic [31:0]  expiry_ff;
   logic         match;

   assign match      = valid_ff && key_len_ff == key_len && key_ff == key;
   assign hit        = match && !chain_in.hit_found;
   assign first_free = !valid_ff && !chain_in.free_found;
   assign chain_out.hit_found  = chain_in.hit_found || match;
   assign chain_out.free_found = chain_in.free_found || !valid_ff;
   assign stored_vlen = vlen_ff;
   assign value      = value_ff;
   assign flags      = flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
      if (wr_en) begin
         key_len_ff <= key_len;
         key_ff     <= key;
         vlen_ff    <= wr_vlen;
         value_ff   <= wr_value;
         flags_ff   <= wr_flags;
         expiry_ff  <= wr_expiry;
      end
   end

   // Expiry is stored but not output; it never gates a hit.
   logic unused_expiry;
   assign unused_expiry = ^expiry_ff;
endmodule

// File: rtl/key_value_table_get_set.sv
// Top level of the fully associative key/value table.
// Depends on kvt_pkg and kvt_cell.
//
// Usage: a get or set transaction enters on the req_ channel (valid/ready).
// In the cycle it is accepted every entry cell compares its stored length
// and key against the masked request key, and a priority chain through the
// row of cells picks the lowest hit and the lowest free entry. At the next
// edge a set writes the chosen cell and the single response is captured in
// the output register; a get captures the hit cell's value and flags.
// The response is offered on the rsp_ channel in the cycle after acceptance.
// One transaction is in flight at a time: the single response register must
// drain before the next request is taken. While rsp_valid is high and
// rsp_ready low the response holds and req_ready stays low. Reset empties
// every entry (valid bits cleared) and drops any pending response; stored
// keys and values are not cleared.
// A bad key length gives an error on get and set; a bad value length gives
// an error on set. A set with no match and no free entry overwrites entry 0.
module key_value_table_get_set
   import kvt_pkg::*;
#(
   parameter int ENTRIES     = 64,
   parameter int KEY_BYTES   = 16,
   parameter int VALUE_BYTES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_type,
   input  logic [7:0]   req_key_len,
   input  logic [63:0]  req_key_lo,
   input  logic [63:0]  req_key_hi,
   input  logic [7:0]   req_value_len,
   input  logic [63:0]  req_value_lo,
   input  logic [63:0]  req_value_hi,
   input  logic [31:0]  req_item_flags,
   input  logic [31:0]  req_expiry_time,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_resp_type,
   output logic [4:0]   rsp_out_key_len,
   output logic [63:0]  rsp_out_key_lo,
   output logic [63:0]  rsp_out_key_hi,
   output logic [4:0]   rsp_out_value_len,
   output logic [63:0]  rsp_out_value_lo,
   output logic [63:0]  rsp_out_value_hi,
   output logic [31:0]  rsp_out_flags
);
   logic accept;
   logic key_bad, value_bad;
   logic [4:0]   klen, vlen;
   logic [127:0] key_m, value_m;

   chain_type    chain [ENTRIES+1];
   logic [ENTRIES-1:0] hit_vec, free_vec, wr_vec;
   logic [4:0]   cell_vlen  [ENTRIES];
   logic [127:0] cell_value [ENTRIES];
   logic [31:0]  cell_flags [ENTRIES];

   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   type_ff, type_in;
   logic [4:0]   klen_ff, klen_in, vlen_ff, vlen_in;
   logic [127:0] key_ff, key_in, value_ff, value_in;
   logic [31:0]  flags_ff, flags_in;

   assign req_ready = !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // Lengths are range checked at full width before narrowing.
   assign key_bad   = req_key_len == 8'd0 || req_key_len > 8'(KEY_BYTES);
   assign value_bad = req_value_len > 8'(VALUE_BYTES);
   assign klen      = req_key_len[4:0];
   assign vlen      = req_value_len[4:0];
   assign key_m     = {req_key_hi & byte_mask(klen, 5'd8), req_key_lo & byte_mask(klen, 5'd0)};
   assign value_m   = {req_value_hi & byte_mask(vlen, 5'd8),
                       req_value_lo & byte_mask(vlen, 5'd0)};

   assign chain[0] = '0;

   // A set goes to the matching entry, else the first free one, else entry 0.
   always_comb begin
      wr_vec = '0;
      if (accept && req_type == REQ_SET && !key_bad && !value_bad) begin
         if (chain[ENTRIES].hit_found)       wr_vec = hit_vec;
         else if (chain[ENTRIES].free_found) wr_vec = free_vec;
         else                                wr_vec[0] = 1'b1;
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      kvt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .key_len      (klen),
         .key          (key_m),
         .wr_en        (wr_vec[g]),
         .wr_vlen      (vlen),
         .wr_value     (value_m),
         .wr_flags     (req_item_flags),
         .wr_expiry    (req_expiry_time),
         .chain_in     (chain[g]),
         .chain_out    (chain[g+1]),
         .hit          (hit_vec[g]),
         .first_free   (free_vec[g]),
         .stored_vlen  (cell_vlen[g]),
         .value        (cell_value[g]),
         .flags        (cell_flags[g])
      );
   end

   // The hit vector is one-hot, so the read mux is an OR of gated words.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      type_in  = type_ff;
      klen_in  = klen_ff;
      key_in   = key_ff;
      vlen_in  = vlen_ff;
      value_in = value_ff;
      flags_in = flags_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         klen_in  = '0;
         key_in   = '0;
         vlen_in  = '0;
         value_in = '0;
         flags_in = '0;
         if (key_bad) begin
            type_in = RSP_ERROR;
         end else if (req_type == REQ_SET) begin
            type_in = value_bad ? RSP_ERROR : RSP_STORED;
         end else if (!chain[ENTRIES].hit_found) begin
            type_in = RSP_MISS;
         end else begin
            type_in = RSP_FOUND;
            klen_in = klen;
            key_in  = key_m;
            for (int i = 0; i < ENTRIES; i++) begin
               if (hit_vec[i]) begin
                  vlen_in  = vlen_in | cell_vlen[i];
                  value_in = value_in | cell_value[i];
                  flags_in = flags_in | cell_flags[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff  <= type_in;
      klen_ff  <= klen_in;
      key_ff   <= key_in;
      vlen_ff  <= vlen_in;
      value_ff <= value_in;
      flags_ff <= flags_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_resp_type     = type_ff;
   assign rsp_out_key_len   = klen_ff;
   assign rsp_out_key_lo    = key_ff[63:0];
   assign rsp_out_key_hi    = key_ff[127:64];
   assign rsp_out_value_len = vlen_ff;
   assign rsp_out_value_lo  = value_ff[63:0];
   assign rsp_out_value_hi  = value_ff[127:64];
   assign rsp_out_flags     = flags_ff;

`ifndef SYNTHESIS
   // At most one entry is written per transaction.
   a_one_write: assert property (@(posedge clock) disable iff (reset) $onehot0(wr_vec))
      else $error("more than one entry written");
   // Priority chain yields at most one hit.
   a_one_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hit_vec))
      else $error("multiple hits selected");
   // An accepted transaction is answered in the next cycle.
   a_rsp_next: assert property (@(posedge clock) disable iff (reset) accept |=> rsp_valid)
      else $error("response missing after accept");
   // No request is taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !accept)
      else $error("request accepted with response pending");
`endif
endmodule
